>>> design/sct_pkg.sv
`default_nettype none

package sct_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_ETU_PERIOD  = 2'd0,
        REG_CLOCK_LOSS_LIMIT = 2'd1,
        REG_START_TIMEOUT    = 2'd2
    } t_cfg_reg;

    // item actions
    typedef enum logic [1:0] {
        ACT_SEND  = 2'd0,
        ACT_RECV  = 2'd1,
        ACT_CLOCK = 2'd2,
        ACT_TICK  = 2'd3
    } t_action;

    // frame result codes
    typedef enum logic [3:0] {
        ST_NONE         = 4'd0,
        ST_SENT         = 4'd1,
        ST_LINE_LOW     = 4'd2,
        ST_SEND_TIMEOUT = 4'd3,
        ST_ERROR_SIGNAL = 4'd4,
        ST_RECEIVED     = 4'd5,
        ST_RECV_TIMEOUT = 4'd6,
        ST_BAD_START    = 4'd7,
        ST_PARITY       = 4'd8,
        ST_BAD_STOP     = 4'd9
    } t_status;

    // frame modes, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_SEND = 4'b0010,
        MODE_WAIT = 4'b0100,
        MODE_RECV = 4'b1000
    } t_mode;

    // reset values of the configuration registers
    localparam logic [11:0] HALF_ETU_RESET   = 12'd187;
    localparam logic [15:0] LOSS_LIMIT_RESET = 16'd10;
    localparam logic [31:0] START_TO_RESET   = 32'd1000;

    // saturation value of the half-etu index
    localparam logic [4:0] IDX_MAX = 5'd31;

    typedef struct packed {
        logic [11:0] half_etu_period;
        logic [15:0] clock_loss_limit;
        logic [31:0] start_timeout;
    } t_cfg;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        t_status     status;
        logic [7:0]  rx_data;
    } t_result;

endpackage

`default_nettype wire

>>> design/sct_if.sv
`default_nettype none

// input item channel
interface sct_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] tx_data;
    logic       line_level;

    modport source (output valid, output action, output tx_data, output line_level,
                    input ready);
    modport sink (input valid, input action, input tx_data, input line_level,
                  output ready);
endinterface

// result item channel
interface sct_result_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [3:0] status;
    logic [7:0] rx_data;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output status, output rx_data, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input status, input rx_data, output ready);
endinterface

// configuration write channel
interface sct_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/sct_frame_core.sv
`default_nettype none

module sct_frame_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_tx_data,
    input  logic             i_line_level,
    input  sct_pkg::t_cfg    i_cfg,
    output sct_pkg::t_result o_result
);
    import sct_pkg::*;

    t_mode       r_mode,  n_mode;
    logic [4:0]  r_idx,   n_idx;
    logic [11:0] r_pre,   n_pre;
    logic [7:0]  r_shift, n_shift;
    logic        r_par,   n_par;
    logic [31:0] r_wd,    n_wd;
    logic        r_drive, n_drive;

    t_status     w_status;
    logic [4:0]  w_k;
    logic [2:0]  w_bit;
    logic [31:0] w_wd_inc;

    // next half-etu index, watchdog increment and data bit of that index
    assign w_k      = (r_idx == IDX_MAX) ? IDX_MAX : r_idx + 5'd1;
    assign w_bit    = 3'(w_k[4:1] - 4'd1);
    assign w_wd_inc = (r_wd == '1) ? r_wd : r_wd + 32'd1;

    // frame state machine
    always_comb begin
        n_mode   = r_mode;
        n_idx    = r_idx;
        n_pre    = r_pre;
        n_shift  = r_shift;
        n_par    = r_par;
        n_wd     = r_wd;
        n_drive  = r_drive;
        w_status = ST_NONE;
        case (r_mode)
            MODE_IDLE: begin
                if (i_action == ACT_SEND) begin
                    if (!i_line_level) begin
                        w_status = ST_LINE_LOW;
                    end else begin
                        n_shift = i_tx_data;
                        n_par   = ^i_tx_data;
                        n_drive = 1'b1;
                        n_mode  = MODE_SEND;
                        n_idx   = '0;
                        n_pre   = '0;
                        n_wd    = '0;
                    end
                end else if (i_action == ACT_RECV) begin
                    n_shift = '0;
                    n_par   = 1'b0;
                    n_wd    = '0;
                    if (!i_line_level) begin
                        n_mode = MODE_RECV;
                        n_idx  = '0;
                        n_pre  = '0;
                    end else begin
                        n_mode = MODE_WAIT;
                    end
                end
            end
            MODE_WAIT: begin
                if (!i_line_level) begin
                    n_mode = MODE_RECV;
                    n_idx  = '0;
                    n_pre  = '0;
                    n_wd   = '0;
                end else if (i_action == ACT_TICK) begin
                    n_wd = w_wd_inc;
                    if (w_wd_inc > i_cfg.start_timeout) w_status = ST_RECV_TIMEOUT;
                end
            end
            MODE_SEND, MODE_RECV: begin
                if (i_action == ACT_CLOCK) begin
                    if (r_pre >= i_cfg.half_etu_period) begin
                        n_pre = '0;
                        n_wd  = '0;
                        n_idx = w_k;
                        if (r_mode == MODE_SEND) begin
                            // drive data, parity, release for stop, watch for error
                            if (w_k inside {5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12,
                                            5'd14, 5'd16}) begin
                                n_drive = ~r_shift[w_bit];
                            end else if (w_k == 5'd18) begin
                                n_drive = ~r_par;
                            end else if (w_k == 5'd20) begin
                                n_drive = 1'b0;
                            end else if (w_k == 5'd22 || w_k == 5'd23) begin
                                if (!i_line_level) w_status = ST_ERROR_SIGNAL;
                            end else if (w_k >= 5'd24) begin
                                w_status = ST_SENT;
                            end
                        end else begin
                            // check start, sample data and parity, check stop
                            if (w_k == 5'd1) begin
                                if (i_line_level) w_status = ST_BAD_START;
                            end else if (w_k inside {5'd3, 5'd5, 5'd7, 5'd9, 5'd11,
                                                     5'd13, 5'd15, 5'd17}) begin
                                n_shift = r_shift | (8'(i_line_level) << w_bit);
                            end else if (w_k == 5'd19) begin
                                n_par = i_line_level;
                            end else if (w_k == 5'd20) begin
                                if (r_par != ^r_shift) w_status = ST_PARITY;
                            end else if (w_k >= 5'd21) begin
                                w_status = i_line_level ? ST_RECEIVED : ST_BAD_STOP;
                            end
                        end
                    end else begin
                        n_pre = r_pre + 12'd1;
                    end
                end else if (i_action == ACT_TICK) begin
                    n_wd = w_wd_inc;
                    if (w_wd_inc >= {16'd0, i_cfg.clock_loss_limit}) begin
                        w_status = (r_mode == MODE_SEND) ? ST_SEND_TIMEOUT
                                                         : ST_RECV_TIMEOUT;
                    end
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
        // any frame end releases the line
        if (w_status != ST_NONE) begin
            n_mode  = MODE_IDLE;
            n_drive = 1'b0;
        end
    end

    // result of this item
    always_comb begin
        o_result.drive_low = n_drive;
        o_result.busy_res  = (n_mode != MODE_IDLE);
        o_result.done_res  = (w_status != ST_NONE);
        o_result.status    = w_status;
        o_result.rx_data   = (w_status == ST_RECEIVED) ? r_shift : 8'd0;
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_idx   <= '0;
            r_pre   <= '0;
            r_shift <= '0;
            r_par   <= 1'b0;
            r_wd    <= '0;
            r_drive <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_idx   <= n_idx;
            r_pre   <= n_pre;
            r_shift <= n_shift;
            r_par   <= n_par;
            r_wd    <= n_wd;
            r_drive <= n_drive;
        end
    end

endmodule

`default_nettype wire

>>> design/smart_card_char_transceiver_unit.sv
// Card-side character layer of a half-duplex smart card I/O line.
// i_item carries one action per item (send byte, arm receive, card clock
// edge, system tick) together with the sampled line level; o_result returns
// exactly one item per input item with the line drive, busy flag, frame-done
// flag, status code and received byte.
// i_cfg writes the half-etu period, clock loss limit and start timeout; the
// write is taken in any cycle and acts on the next item.
// When an item is accepted, the frame state updates and the result sits in
// the output register on the next cycle. Throughput is one item per cycle
// while o_result does not stall, set by the single result register; the
// frame state machine and counters update in the accept cycle.
// While a result waits in the output register and o_result stalls, i_item
// is not ready; it is ready when that register is empty or taken this cycle.
// Reset (synchronous, active low) clears the frame to idle with the line
// released, empties the output register and loads the default period 187,
// loss limit 10 and start timeout 1000.
`default_nettype none

module smart_card_char_transceiver_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sct_item_if.sink      i_item,
    sct_cfg_if.sink       i_cfg,
    sct_result_if.source  o_result
);
    import sct_pkg::*;

    t_cfg    r_cfg;
    t_result w_res;
    t_result r_res;
    logic    r_out_valid;
    logic    w_accept;

    // handshakes
    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_etu_period  <= HALF_ETU_RESET;
            r_cfg.clock_loss_limit <= LOSS_LIMIT_RESET;
            r_cfg.start_timeout    <= START_TO_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_HALF_ETU_PERIOD)  r_cfg.half_etu_period  <= i_cfg.data[11:0];
            if (i_cfg.index == REG_CLOCK_LOSS_LIMIT) r_cfg.clock_loss_limit <= i_cfg.data[15:0];
            if (i_cfg.index == REG_START_TIMEOUT)    r_cfg.start_timeout    <= i_cfg.data;
        end
    end

    // frame engine
    sct_frame_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_accept),
        .i_action     (i_item.action),
        .i_tx_data    (i_item.tx_data),
        .i_line_level (i_item.line_level),
        .i_cfg        (r_cfg),
        .o_result     (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_res;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.drive_low = r_res.drive_low;
    assign o_result.busy_res  = r_res.busy_res;
    assign o_result.done_res  = r_res.done_res;
    assign o_result.status    = r_res.status;
    assign o_result.rx_data   = r_res.rx_data;

endmodule

`default_nettype wire

>>> tb/smart_card_char_transceiver_unit_tb.sv
module smart_card_char_transceiver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sct_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // index that maps to no register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE    = 2'd0,
        STALL_COIN    = 2'd1,
        STALL_PATTERN = 2'd2,
        STALL_HEAVY   = 2'd3
    } t_stall;

    typedef struct packed {
        logic                 is_cfg;
        t_action              act;
        logic [7:0]           data;
        logic                 lvl;
        logic                 typed;
        t_result              want;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [31:0]          cfg_val;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sct_item_if   item_ch ();
    sct_cfg_if    cfg_ch ();
    sct_result_if res_ch ();

    smart_card_char_transceiver_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // own copy of the character layer state
    t_cfg        cfg_q;
    t_mode       fr_mode;
    logic [4:0]  half_idx;
    logic [11:0] pre_cnt;
    logic [7:0]  shift_q;
    logic        par_q;
    logic [31:0] wdog;
    logic        drive_q;

    t_result     pending_results[$];
    t_dir_row    dir_rows[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // stimulus shaping state
    logic [10:0] rx_slots;
    int          hold_high_items;
    int          tick_div;
    int          burst_left;

    // receiver stall state
    t_stall      rdy_style;
    int          rdy_left = 0;
    logic [15:0] rdy_pat;
    logic [31:0] rdy_word;

    function automatic void restart_frame_at(input t_mode m);
        fr_mode  = m;
        half_idx = '0;
        pre_cnt  = '0;
        wdog     = '0;
    endfunction

    // one item through the character layer, returns the line result
    function automatic t_result step_char_layer(input t_action act, input logic [7:0] data,
                                                input logic lvl);
        t_status    st;
        t_result    r;
        logic [4:0] k;
        int         bidx;
        st = ST_NONE;
        r  = '0;
        if (fr_mode == MODE_IDLE) begin
            if (act == ACT_SEND) begin
                if (!lvl) begin
                    st = ST_LINE_LOW;
                end else begin
                    shift_q = data;
                    par_q   = ^data;
                    drive_q = 1'b1;
                    restart_frame_at(MODE_SEND);
                end
            end else if (act == ACT_RECV) begin
                shift_q = '0;
                par_q   = 1'b0;
                if (!lvl) begin
                    restart_frame_at(MODE_RECV);
                end else begin
                    fr_mode = MODE_WAIT;
                    wdog    = '0;
                end
            end
        end else if (fr_mode == MODE_WAIT) begin
            // any low line starts the frame, otherwise ticks count toward the start timeout
            if (!lvl) begin
                restart_frame_at(MODE_RECV);
            end else if (act == ACT_TICK) begin
                if (wdog != '1) wdog = wdog + 32'd1;
                if (wdog > cfg_q.start_timeout) st = ST_RECV_TIMEOUT;
            end
        end else if (act == ACT_CLOCK) begin
            if (pre_cnt >= cfg_q.half_etu_period) begin
                pre_cnt = '0;
                wdog    = '0;
                if (half_idx < IDX_MAX) half_idx = half_idx + 5'd1;
                k = half_idx;
                if (fr_mode == MODE_SEND) begin
                    // start bit, data lsb first, parity, then released for the error window
                    if (k >= 5'd2 && k <= 5'd16 && !k[0]) begin
                        bidx = (k - 5'd2) / 2;
                        drive_q = !shift_q[bidx];
                    end else if (k == 5'd18) begin
                        drive_q = !par_q;
                    end else if (k == 5'd20) begin
                        drive_q = 1'b0;
                    end else if (k == 5'd22 || k == 5'd23) begin
                        if (!lvl) st = ST_ERROR_SIGNAL;
                    end else if (k >= 5'd24) begin
                        st = ST_SENT;
                    end
                end else begin
                    if (k == 5'd1) begin
                        if (lvl) st = ST_BAD_START;
                    end else if (k >= 5'd3 && k <= 5'd17 && k[0]) begin
                        bidx = (k - 5'd3) / 2;
                        if (lvl) shift_q[bidx] = 1'b1;
                    end else if (k == 5'd19) begin
                        par_q = lvl;
                    end else if (k == 5'd20) begin
                        if (par_q != ^shift_q) st = ST_PARITY;
                    end else if (k >= 5'd21) begin
                        st = lvl ? ST_RECEIVED : ST_BAD_STOP;
                    end
                end
            end else begin
                pre_cnt = pre_cnt + 12'd1;
            end
        end else if (act == ACT_TICK) begin
            // clock loss watchdog
            if (wdog != '1) wdog = wdog + 32'd1;
            if (wdog >= {16'd0, cfg_q.clock_loss_limit})
                st = (fr_mode == MODE_SEND) ? ST_SEND_TIMEOUT : ST_RECV_TIMEOUT;
        end
        if (st != ST_NONE) begin
            if (st == ST_RECEIVED) r.rx_data = shift_q;
            fr_mode = MODE_IDLE;
            drive_q = 1'b0;
        end
        r.drive_low = drive_q;
        r.busy_res  = (fr_mode != MODE_IDLE);
        r.done_res  = (st != ST_NONE);
        r.status    = st;
        return r;
    endfunction

    // next random item, shaped by the current frame state
    task automatic pick_random_item(output t_action act, output logic [7:0] data,
                                    output logic lvl);
        int          r;
        logic [31:0] rnd;
        logic [31:0] bw;
        logic [4:0]  k;
        logic        p;
        r    = $urandom_range(0, 99);
        rnd  = $urandom;
        data = rnd[7:0];
        lvl  = rnd[10];
        act  = ACT_TICK;
        if (fr_mode == MODE_IDLE) begin
            if (r < 45) begin
                act = ACT_SEND;
                lvl = ($urandom_range(0, 15) != 0);
            end else if (r < 85) begin
                act = ACT_RECV;
                lvl = ($urandom_range(0, 9) != 0);
                // line pattern of the character the terminal will send
                bw = $urandom;
                p  = ^bw[7:0];
                if ($urandom_range(0, 7) == 0) p = !p;
                rx_slots = {($urandom_range(0, 9) != 0), p, bw[7:0],
                            ($urandom_range(0, 15) == 0)};
                hold_high_items = $urandom_range(0, 40);
            end else begin
                act = t_action'(rnd[9:8]);
            end
        end else if (fr_mode == MODE_WAIT) begin
            if (hold_high_items == 0) begin
                act = t_action'(rnd[9:8]);
                lvl = 1'b0;
            end else begin
                hold_high_items--;
                lvl = 1'b1;
                if (r < 60) act = ACT_TICK;
                else if (r < 90) act = ACT_CLOCK;
                else act = (r < 95) ? ACT_SEND : ACT_RECV;
            end
        end else begin
            if (r < 3) begin
                act = rnd[11] ? ACT_SEND : ACT_RECV;
            end else if ($urandom_range(1, tick_div) == 1) begin
                act = ACT_TICK;
            end else begin
                act = ACT_CLOCK;
                if (pre_cnt >= cfg_q.half_etu_period) begin
                    k = (half_idx < IDX_MAX) ? half_idx + 5'd1 : IDX_MAX;
                    if (fr_mode == MODE_SEND) begin
                        if (k == 5'd22 || k == 5'd23) lvl = ($urandom_range(0, 7) != 0);
                    end else if (k <= 5'd21) begin
                        lvl = rx_slots[k >> 1];
                        if ($urandom_range(0, 49) == 0) lvl = !lvl;
                    end
                end
            end
        end
    endtask

    // drive one item and record what it should produce
    task automatic send_one(input t_action act, input logic [7:0] data, input logic lvl,
                            input logic typed, input t_result want, input logic last);
        t_result got;
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.tx_data    <= data;
        item_ch.line_level <= lvl;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        got = step_char_layer(act, data, lvl);
        pending_results.push_back(typed ? want : got);
        if (burst_left > 0) burst_left--;
        if (last || burst_left == 0) begin
            item_ch.valid <= 1'b0;
            repeat (last ? 1 : $urandom_range(1, 10)) @(posedge i_clk);
            if (burst_left == 0)
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 30);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] w);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= w;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_HALF_ETU_PERIOD:  cfg_q.half_etu_period  = w[11:0];
            REG_CLOCK_LOSS_LIMIT: cfg_q.clock_loss_limit = w[15:0];
            REG_START_TIMEOUT:    cfg_q.start_timeout    = w;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle_results();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_item(input t_action act, input logic [7:0] data, input logic lvl,
                            input logic typed, input logic drv, input logic busy,
                            input logic done, input t_status st);
        t_dir_row row;
        row                = '0;
        row.act            = act;
        row.data           = data;
        row.lvl            = lvl;
        row.typed          = typed;
        row.want.drive_low = drv;
        row.want.busy_res  = busy;
        row.want.done_res  = done;
        row.want.status    = st;
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] w);
        t_dir_row row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = w;
        dir_rows.push_back(row);
    endtask

    // one setting of the registers followed by random traffic
    task automatic run_phase(input logic [11:0] per, input logic [15:0] loss,
                             input logic [31:0] sto, input int n, input int tdiv);
        logic [31:0] w;
        t_action     act;
        logic [7:0]  data;
        logic        lvl;
        settle_results();
        // upper bits beyond the register width carry noise
        w = $urandom;
        w[11:0] = per;
        write_reg(REG_HALF_ETU_PERIOD, w);
        w = $urandom;
        w[15:0] = loss;
        write_reg(REG_CLOCK_LOSS_LIMIT, w);
        write_reg(REG_START_TIMEOUT, sto);
        tick_div = tdiv;
        for (int i = 0; i < n; i++) begin
            pick_random_item(act, data, lvl);
            send_one(act, data, lvl, 1'b0, '0, i == n - 1);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no pending input item");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.drive_low !== want.drive_low) begin
                    $error("drive_low expected %0d actual %0d", want.drive_low,
                           res_ch.drive_low);
                    mismatch_count++;
                end
                if (res_ch.busy_res !== want.busy_res) begin
                    $error("busy_res expected %0d actual %0d", want.busy_res, res_ch.busy_res);
                    mismatch_count++;
                end
                if (res_ch.done_res !== want.done_res) begin
                    $error("done_res expected %0d actual %0d", want.done_res, res_ch.done_res);
                    mismatch_count++;
                end
                if (res_ch.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, res_ch.status);
                    mismatch_count++;
                end
                if (res_ch.rx_data !== want.rx_data) begin
                    $error("rx_data expected %0d actual %0d", want.rx_data, res_ch.rx_data);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver back-pressure, style is redrawn at random intervals
    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_word  = $urandom;
            rdy_style = t_stall'(rdy_word[17:16]);
            rdy_pat   = rdy_word[15:0];
            rdy_left  = $urandom_range(20, 300);
        end else begin
            rdy_left--;
        end
        rdy_pat = {rdy_pat[14:0], rdy_pat[15]};
        case (rdy_style)
            STALL_NONE:    res_ch.ready <= 1'b1;
            STALL_COIN:    res_ch.ready <= ($urandom_range(0, 1) == 1);
            STALL_PATTERN: res_ch.ready <= rdy_pat[0];
            default:       res_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.action     <= ACT_TICK;
        item_ch.tx_data    <= 8'h00;
        item_ch.line_level <= 1'b1;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_HALF_ETU_PERIOD;
        cfg_ch.data        <= 32'd0;
        cfg_q.half_etu_period  = HALF_ETU_RESET;
        cfg_q.clock_loss_limit = LOSS_LIMIT_RESET;
        cfg_q.start_timeout    = START_TO_RESET;
        fr_mode         = MODE_IDLE;
        half_idx        = '0;
        pre_cnt         = '0;
        shift_q         = '0;
        par_q           = 1'b0;
        wdog            = '0;
        drive_q         = 1'b0;
        hold_high_items = 0;
        rx_slots        = '0;
        tick_div        = 8;
        burst_left      = $urandom_range(1, 30);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle clocks and ticks do nothing, send on a low line fails at once
        add_item(ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, ST_NONE);
        add_item(ACT_CLOCK, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ST_NONE);
        add_item(ACT_SEND,  8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, ST_LINE_LOW);
        // armed receive ignores commands, low line on a clock starts the frame
        add_item(ACT_RECV,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, ST_NONE);
        add_item(ACT_SEND,  8'h55, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, ST_NONE);
        add_item(ACT_TICK,  8'hAA, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, ST_NONE);
        add_item(ACT_CLOCK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, ST_NONE);
        // zero loss limit written mid frame, first tick times out
        add_cfg(REG_CLOCK_LOSS_LIMIT, 32'd0);
        add_item(ACT_TICK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ST_RECV_TIMEOUT);
        // zero period, every clock edge is a half-etu
        add_cfg(REG_HALF_ETU_PERIOD, 32'd0);
        add_cfg(REG_CLOCK_LOSS_LIMIT, 32'h0000_FFFF);
        add_item(ACT_SEND,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, ST_NONE);
        add_item(ACT_CLOCK, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ST_NONE);
        add_item(ACT_CLOCK, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ST_NONE);
        add_item(ACT_RECV,  8'h12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_NONE);
        add_item(ACT_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_NONE);
        add_cfg(REG_CLOCK_LOSS_LIMIT, 32'd1);
        add_item(ACT_TICK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ST_SEND_TIMEOUT);
        // start detection on the arming item, then a high start bit
        add_cfg(REG_START_TIMEOUT, 32'd0);
        add_item(ACT_RECV,  8'hFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, ST_NONE);
        add_item(ACT_CLOCK, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ST_BAD_START);
        // zero start timeout expires on the first tick
        add_item(ACT_RECV,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, ST_NONE);
        add_item(ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ST_RECV_TIMEOUT);
        // all-ones start timeout never expires, low line on a command starts
        add_cfg(REG_START_TIMEOUT, 32'hFFFF_FFFF);
        add_item(ACT_RECV,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, ST_NONE);
        add_item(ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, ST_NONE);
        add_item(ACT_SEND,  8'hFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, ST_NONE);
        add_item(ACT_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ST_RECV_TIMEOUT);

        for (int i = 0; i < dir_rows.size(); i++) begin
            if (dir_rows[i].is_cfg) begin
                settle_results();
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            end else begin
                send_one(dir_rows[i].act, dir_rows[i].data, dir_rows[i].lvl,
                         dir_rows[i].typed, dir_rows[i].want,
                         (i == dir_rows.size() - 1) || dir_rows[i + 1].is_cfg);
            end
        end

        // random traffic over several register settings
        run_phase(12'd0,    16'd0,     32'd0,           150, 50);
        run_phase(12'd1,    16'd3,     32'd5,           300, 12);
        run_phase(12'd2,    16'd20,    32'd40,          300, 6);
        run_phase(12'd3,    16'hFFFF,  32'hFFFF_FFFF,   300, 4);
        run_phase(12'd0,    16'd1,     32'd10,          250, 40);
        settle_results();
        write_reg(REG_UNUSED, $urandom);
        run_phase(12'hFFF,  16'd10,    32'd1000,        150, 8);
        run_phase(12'd5,    16'd8,     32'd2,           300, 5);
        run_phase(12'd1,    16'd200,   32'h8000_0000,   250, 3);

        settle_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
